FILE: design/crws_pkg.sv
package crws_pkg;

    localparam int COIL_BITS = 256;
    localparam int WORDS     = COIL_BITS / 8;
    localparam int WORD_AW   = $clog2(WORDS);
    localparam int OFF_W     = $clog2(COIL_BITS);
    localparam int POS_W     = 9;
    localparam int DATA_POS  = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam logic [POS_W-1:0] POS_MAX = 9'd511;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVED = 1'b1;

    localparam logic [7:0] FC_READ   = 8'h01;
    localparam logic [7:0] FC_WRITE  = 8'h0F;
    localparam logic [7:0] EXC_FLAG  = 8'h80;
    localparam logic [7:0] EXC_FUNC  = 8'h01;
    localparam logic [7:0] EXC_RANGE = 8'h02;

    typedef enum logic [8:0] {
        S_RX       = 9'b000000001,
        S_EVAL     = 9'b000000010,
        S_HDR      = 9'b000000100,
        S_RD_PRIME = 9'b000001000,
        S_RD_LO    = 9'b000010000,
        S_RD_ISSUE = 9'b000100000,
        S_RD_EMIT  = 9'b001000000,
        S_WR_ISSUE = 9'b010000000,
        S_WR_MERGE = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        K_ERR_RANGE,
        K_ERR_FUNC,
        K_READ,
        K_WRITE
    } resp_kind_t;

    // ones in the bits below n, all ones from eight up
    function automatic logic [7:0] low_mask(input logic [9:0] n);
        logic [7:0] m;
        if (n >= 10'd8) begin
            m = 8'hFF;
        end else begin
            m = ~(8'hFF << n[2:0]);
        end
        return m;
    endfunction

endpackage

FILE: design/coil_read_write_request_server.sv
// channel   direction  ports                                        word
// s_        in         s_valid s_ready s_request_byte s_last_of_request   request byte
// m_        out        m_valid m_ready m_response_byte m_last_of_response response byte
// cfg_      in         cfg_wr_en cfg_index cfg_data                      register write
//
// request bytes are taken in S_RX; after the last byte S_EVAL checks the range
// header and exception bytes go out from S_HDR; a read primes in S_RD_PRIME and
// S_RD_LO, then runs S_RD_ISSUE and S_RD_EMIT per byte (single coil read port)
// a write runs a read-modify-write over the coil words, S_WR_ISSUE then S_WR_MERGE per word
// reset clears per-word valid bits at once, so no clearing pass is needed
// a stalled result holds in the output register and stalls the sequencer
module coil_read_write_request_server (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_request_byte,
    input  logic                            s_last_of_request,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_response_byte,
    output logic                            m_last_of_response,
    input  logic                            cfg_wr_en,
    input  logic [crws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crws_pkg::CFG_W-1:0]      cfg_data
);

    localparam int AW = crws_pkg::WORD_AW;

    crws_pkg::state_t     state_reg, state_next;
    crws_pkg::resp_kind_t kind_reg, kind_next;

    logic [crws_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0]                 fc_reg, fc_next;
    logic [15:0]                start_reg, start_next;
    logic [15:0]                count_reg, count_next;
    logic [15:0]                base_reg, base_next;
    logic [8:0]                 served_reg, served_next;
    logic [crws_pkg::WORDS-1:0] st_valid_reg, st_valid_next;
    logic                       m_valid_reg, m_valid_next;
    logic [7:0]                 m_byte_reg, m_byte_next;
    logic                       m_last_reg, m_last_next;

    logic [AW-1:0] w0_reg, w0_next;
    logic [2:0]    sh_reg, sh_next;
    logic [AW:0]   nbytes_reg, nbytes_next;
    logic [AW:0]   nw_reg, nw_next;
    logic [2:0]    idx_reg, idx_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW-1:0] m_reg, m_next;
    logic [7:0]    lo_reg, lo_next;
    logic [7:0]    pend_prev_reg, pend_prev_next;
    logic          st_ok_reg, st_ok_next;

    logic          rx_accept, can_push;
    logic          st_we, st_re, pend_we, pend_re;
    logic [AW-1:0] st_waddr, pend_waddr;
    logic [AW:0]   st_raddr;
    logic [7:0]    st_wdata, st_rdata, pend_rdata, st_word;

    logic [8:0]                 served_clamp;
    logic [16:0]                end_req, end_win;
    logic                       bad_range;
    logic [15:0]                off16;
    logic [crws_pkg::OFF_W-1:0] off;
    logic [9:0]                 nw_sum, nb_sum;
    logic [crws_pkg::POS_W-1:0] pd;

    logic [7:0]  hdr_byte;
    logic        hdr_last;
    logic [15:0] rd_pair, wr_pair;
    logic [9:0]  rem, lim;
    logic [7:0]  rd_byte, wr_ins, wr_mask;

    assign rx_accept = s_valid && s_ready;
    assign s_ready   = (state_reg == crws_pkg::S_RX);
    assign can_push  = !m_valid_reg || m_ready;
    assign st_word   = st_ok_reg ? st_rdata : 8'h00;

    // range check and geometry of the addressed window
    assign served_clamp = (served_reg > 9'(crws_pkg::COIL_BITS))
                          ? 9'(crws_pkg::COIL_BITS) : served_reg;
    assign end_req   = {1'b0, start_reg} + {1'b0, count_reg};
    assign end_win   = {1'b0, base_reg} + {8'b0, served_clamp};
    assign bad_range = (start_reg < base_reg) || (end_req > end_win);
    assign off16     = start_reg - base_reg;
    assign off       = off16[crws_pkg::OFF_W-1:0];
    assign nw_sum    = {7'b0, off[2:0]} + {1'b0, count_reg[8:0]} + 10'd7;
    assign nb_sum    = {1'b0, count_reg[8:0]} + 10'd7;

    // data bytes of the request go to the pending memory
    assign pd         = pos_reg - crws_pkg::POS_W'(crws_pkg::DATA_POS);
    assign pend_waddr = pd[AW-1:0];
    assign pend_we    = rx_accept
                        && (pos_reg >= crws_pkg::POS_W'(crws_pkg::DATA_POS))
                        && (pos_reg < crws_pkg::POS_W'(crws_pkg::DATA_POS + crws_pkg::WORDS));
    assign pend_re    = (state_reg == crws_pkg::S_WR_ISSUE);

    // read response byte from two adjacent coil words
    assign rd_pair = {st_word, lo_reg} >> sh_reg;
    assign rem     = {1'b0, count_reg[8:0]} - {2'b0, k_reg, 3'b000};
    assign rd_byte = rd_pair[7:0] & crws_pkg::low_mask(rem);

    // write merge of pending bits into one coil word
    assign wr_pair  = {pend_rdata, pend_prev_reg} << sh_reg;
    assign wr_ins   = wr_pair[15:8];
    assign lim      = {1'b0, count_reg[8:0]} + {7'b0, sh_reg} - {2'b0, m_reg, 3'b000};
    assign wr_mask  = crws_pkg::low_mask(lim)
                      & ((m_reg == '0) ? (8'hFF << sh_reg) : 8'hFF);
    assign st_wdata = (st_word & ~wr_mask) | (wr_ins & wr_mask);
    assign st_waddr = w0_reg + m_reg;
    assign st_we    = (state_reg == crws_pkg::S_WR_MERGE);

    always_comb begin
        st_re    = 1'b0;
        st_raddr = {1'b0, w0_reg};
        unique case (state_reg)
            crws_pkg::S_RD_PRIME: begin
                st_re    = 1'b1;
                st_raddr = {1'b0, w0_reg};
            end
            crws_pkg::S_RD_ISSUE: begin
                st_re    = 1'b1;
                st_raddr = {1'b0, w0_reg} + {1'b0, k_reg} + (AW+1)'(1);
            end
            crws_pkg::S_WR_ISSUE: begin
                st_re    = 1'b1;
                st_raddr = {1'b0, w0_reg} + {1'b0, m_reg};
            end
            default: begin
                st_re    = 1'b0;
                st_raddr = {1'b0, w0_reg};
            end
        endcase
    end

    always_comb begin
        hdr_byte = 8'h00;
        hdr_last = 1'b0;
        unique case (kind_reg)
            crws_pkg::K_ERR_RANGE, crws_pkg::K_ERR_FUNC: begin
                if (idx_reg == 3'd0) begin
                    hdr_byte = fc_reg + crws_pkg::EXC_FLAG;
                end else begin
                    hdr_byte = (kind_reg == crws_pkg::K_ERR_RANGE)
                               ? crws_pkg::EXC_RANGE : crws_pkg::EXC_FUNC;
                    hdr_last = 1'b1;
                end
            end
            crws_pkg::K_READ: begin
                if (idx_reg == 3'd0) begin
                    hdr_byte = crws_pkg::FC_READ;
                end else begin
                    hdr_byte = 8'(nbytes_reg);
                    hdr_last = (nbytes_reg == '0);
                end
            end
            crws_pkg::K_WRITE: begin
                unique case (idx_reg)
                    3'd0:    hdr_byte = crws_pkg::FC_WRITE;
                    3'd1:    hdr_byte = start_reg[15:8];
                    3'd2:    hdr_byte = start_reg[7:0];
                    3'd3:    hdr_byte = count_reg[15:8];
                    default: begin
                        hdr_byte = count_reg[7:0];
                        hdr_last = 1'b1;
                    end
                endcase
            end
            default: begin
                hdr_byte = 8'h00;
                hdr_last = 1'b1;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        pos_next       = pos_reg;
        fc_next        = fc_reg;
        start_next     = start_reg;
        count_next     = count_reg;
        base_next      = base_reg;
        served_next    = served_reg;
        st_valid_next  = st_valid_reg;
        w0_next        = w0_reg;
        sh_next        = sh_reg;
        nbytes_next    = nbytes_reg;
        nw_next        = nw_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        m_next         = m_reg;
        lo_next        = lo_reg;
        pend_prev_next = pend_prev_reg;
        st_ok_next     = st_ok_reg;
        m_valid_next   = m_valid_reg;
        m_byte_next    = m_byte_reg;
        m_last_next    = m_last_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            unique case (cfg_index)
                crws_pkg::CFG_BASE:   base_next = cfg_data;
                crws_pkg::CFG_SERVED: served_next = cfg_data[8:0];
                default:              served_next = served_reg;
            endcase
        end

        if (st_re) begin
            st_ok_next = !st_raddr[AW] && st_valid_reg[st_raddr[AW-1:0]];
        end
        if (st_we) begin
            st_valid_next[st_waddr] = 1'b1;
        end

        unique case (state_reg)
            crws_pkg::S_RX: begin
                if (rx_accept) begin
                    priority if (pos_reg == 9'd0) begin
                        fc_next    = s_request_byte;
                        start_next = 16'h0000;
                        count_next = 16'h0000;
                    end else if (pos_reg == 9'd1) begin
                        start_next = {s_request_byte, start_reg[7:0]};
                    end else if (pos_reg == 9'd2) begin
                        start_next = {start_reg[15:8], s_request_byte};
                    end else if (pos_reg == 9'd3) begin
                        count_next = {s_request_byte, count_reg[7:0]};
                    end else if (pos_reg == 9'd4) begin
                        count_next = {count_reg[15:8], s_request_byte};
                    end else begin
                        count_next = count_reg;
                    end
                    if (pos_reg != crws_pkg::POS_MAX) begin
                        pos_next = pos_reg + 9'd1;
                    end
                    if (s_last_of_request) begin
                        pos_next   = '0;
                        state_next = crws_pkg::S_EVAL;
                    end
                end
            end
            crws_pkg::S_EVAL: begin
                w0_next        = off[crws_pkg::OFF_W-1:3];
                sh_next        = off[2:0];
                nbytes_next    = nb_sum[AW+3:3];
                nw_next        = nw_sum[AW+3:3];
                idx_next       = 3'd0;
                k_next         = '0;
                m_next         = '0;
                pend_prev_next = 8'h00;
                state_next     = crws_pkg::S_HDR;
                priority if (bad_range) begin
                    kind_next = crws_pkg::K_ERR_RANGE;
                end else if (fc_reg == crws_pkg::FC_READ) begin
                    kind_next = crws_pkg::K_READ;
                end else if (fc_reg == crws_pkg::FC_WRITE) begin
                    kind_next = crws_pkg::K_WRITE;
                    if (nw_sum[AW+3:3] != '0) begin
                        state_next = crws_pkg::S_WR_ISSUE;
                    end
                end else begin
                    kind_next = crws_pkg::K_ERR_FUNC;
                end
            end
            crws_pkg::S_HDR: begin
                if (can_push) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = hdr_byte;
                    m_last_next  = hdr_last;
                    priority if (hdr_last) begin
                        state_next = crws_pkg::S_RX;
                    end else if (kind_reg == crws_pkg::K_READ && idx_reg == 3'd1) begin
                        state_next = crws_pkg::S_RD_PRIME;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            crws_pkg::S_RD_PRIME: begin
                state_next = crws_pkg::S_RD_LO;
            end
            crws_pkg::S_RD_LO: begin
                lo_next    = st_word;
                state_next = crws_pkg::S_RD_ISSUE;
            end
            crws_pkg::S_RD_ISSUE: begin
                state_next = crws_pkg::S_RD_EMIT;
            end
            crws_pkg::S_RD_EMIT: begin
                if (can_push) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = rd_byte;
                    m_last_next  = ({1'b0, k_reg} + (AW+1)'(1) == nbytes_reg);
                    lo_next      = st_word;
                    if ({1'b0, k_reg} + (AW+1)'(1) == nbytes_reg) begin
                        state_next = crws_pkg::S_RX;
                    end else begin
                        k_next     = k_reg + AW'(1);
                        state_next = crws_pkg::S_RD_ISSUE;
                    end
                end
            end
            crws_pkg::S_WR_ISSUE: begin
                state_next = crws_pkg::S_WR_MERGE;
            end
            crws_pkg::S_WR_MERGE: begin
                pend_prev_next = pend_rdata;
                if ({1'b0, m_reg} + (AW+1)'(1) == nw_reg) begin
                    state_next = crws_pkg::S_HDR;
                end else begin
                    m_next     = m_reg + AW'(1);
                    state_next = crws_pkg::S_WR_ISSUE;
                end
            end
            default: begin
                state_next = crws_pkg::S_RX;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= crws_pkg::S_RX;
            pos_reg      <= '0;
            fc_reg       <= '0;
            start_reg    <= '0;
            count_reg    <= '0;
            base_reg     <= '0;
            served_reg   <= '0;
            st_valid_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            fc_reg       <= fc_next;
            start_reg    <= start_next;
            count_reg    <= count_next;
            base_reg     <= base_next;
            served_reg   <= served_next;
            st_valid_reg <= st_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        w0_reg        <= w0_next;
        sh_reg        <= sh_next;
        nbytes_reg    <= nbytes_next;
        nw_reg        <= nw_next;
        idx_reg       <= idx_next;
        k_reg         <= k_next;
        m_reg         <= m_next;
        lo_reg        <= lo_next;
        pend_prev_reg <= pend_prev_next;
        st_ok_reg     <= st_ok_next;
        m_byte_reg    <= m_byte_next;
        m_last_reg    <= m_last_next;
    end

    crws_ram #(
        .WIDTH(8),
        .DEPTH(crws_pkg::WORDS)
    ) u_coil_ram (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr[AW-1:0]),
        .rdata (st_rdata)
    );

    crws_ram #(
        .WIDTH(8),
        .DEPTH(crws_pkg::WORDS)
    ) u_pend_ram (
        .aclk  (aclk),
        .we    (pend_we),
        .waddr (pend_waddr),
        .wdata (s_request_byte),
        .re    (pend_re),
        .raddr (m_reg),
        .rdata (pend_rdata)
    );

    assign m_valid            = m_valid_reg;
    assign m_response_byte    = m_byte_reg;
    assign m_last_of_response = m_last_reg;

    a_last_to_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (rx_accept && s_last_of_request) |=> (state_reg == crws_pkg::S_EVAL))
        else $error("last request byte did not start evaluation");

    a_pos_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != crws_pkg::S_RX) |-> (pos_reg == '0))
        else $error("byte position not cleared while answering");

    a_rd_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == crws_pkg::S_RD_EMIT) |-> ({1'b0, k_reg} < nbytes_reg))
        else $error("read byte index past byte count");

    a_wr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == crws_pkg::S_WR_MERGE) |-> ({1'b0, m_reg} < nw_reg))
        else $error("write word index past word count");

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> ($stable(m_byte_reg) && $stable(m_last_reg)))
        else $error("response word overwritten while stalled");

endmodule

FILE: design/crws_ram.sv
module crws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
